FILE: rtl/lab_pkg.sv
// Shared constants, register map and CORDIC table for the line array gain block.
package lab_pkg;

  localparam int MAX_ELEMENTS_DEF  = 1024;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int DIR_W    = 16;  // direction cosine, Q1.15
  localparam int FREQ_W   = 20;
  localparam int COUNT_W  = 11;
  localparam int SPACE_W  = 24;
  localparam int SPEED_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int PHASE_W  = 32;  // Q0.32 turns
  localparam int SIN_W    = 31;  // |sin| in Q1.30, always below 2^31
  localparam int CORD_W   = 34;  // CORDIC datapath width
  localparam int MAG_W    = 16;  // |arrival - steer|
  localparam int NUM_W    = SPACE_W + FREQ_W + MAG_W;

  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [CORD_W-1:0] CORDIC_K   = CORD_W'(652032874);
  localparam logic [SIN_W-1:0]  LOBE_FLOOR = SIN_W'(32768);
  localparam logic [GAIN_W-1:0] GAIN_MAX   = '1;

  typedef enum logic [1:0] {
    REG_LINE_AXIS = 2'd0,
    REG_ELEM_CNT  = 2'd1,
    REG_SPACING   = 2'd2,
    REG_SPEED     = 2'd3
  } reg_idx_t;

  // arctangent of 2^-i in Q0.32 turns
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

endpackage

FILE: rtl/lab_if.sv
// Valid/ready channel interfaces for the item and result streams.
interface lab_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] arrival_front;
  logic signed [15:0] arrival_up;
  logic signed [15:0] steer_front;
  logic signed [15:0] steer_up;
  logic [19:0]       frequency_hz;

  modport source (output valid, arrival_front, arrival_up, steer_front, steer_up,
                  frequency_hz, input ready);
  modport sink   (input valid, arrival_front, arrival_up, steer_front, steer_up,
                  frequency_hz, output ready);
endinterface

interface lab_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] gain;

  modport source (output valid, gain, input ready);
  modport sink   (input valid, gain, output ready);
endinterface

FILE: rtl/lab_div.sv
// Pipelined restoring divider, BPS quotient bits per stage, with sideband.
module lab_div #(
  parameter int DW  = 60,
  parameter int VW  = 16,
  parameter int QW  = 32,
  parameter int BPS = 4,
  parameter int SW  = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  output logic [QW-1:0] quot,
  output logic          ovf,       // quotient did not fit in QW bits
  output logic [SW-1:0] out_side
);

  localparam int NS = (DW + BPS - 1) / BPS;
  localparam int PW = NS * BPS;

  logic          v   [NS];
  logic [VW-1:0] rm  [NS];
  logic [PW-1:0] dd  [NS];
  logic [VW-1:0] dv  [NS];
  logic [QW-1:0] q   [NS];
  logic          of  [NS];
  logic [SW-1:0] sb  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic          pv;
    logic [VW-1:0] prm;
    logic [PW-1:0] pdd;
    logic [VW-1:0] pdv;
    logic [QW-1:0] pq;
    logic          pof;
    logic [SW-1:0] psb;
    logic [VW-1:0] nrm;
    logic [PW-1:0] ndd;
    logic [QW-1:0] nq;
    logic          nof;

    if (s == 0) begin : g_first
      assign pv  = in_valid;
      assign prm = '0;
      assign pdd = PW'(dividend);
      assign pdv = divisor;
      assign pq  = '0;
      assign pof = 1'b0;
      assign psb = side;
    end else begin : g_next
      assign pv  = v[s-1];
      assign prm = rm[s-1];
      assign pdd = dd[s-1];
      assign pdv = dv[s-1];
      assign pq  = q[s-1];
      assign pof = of[s-1];
      assign psb = sb[s-1];
    end

    always_comb begin
      logic [VW:0] t;
      nrm = prm;
      ndd = pdd;
      nq  = pq;
      nof = pof;
      for (int k = 0; k < BPS; k++) begin
        t   = {nrm, ndd[PW-1]};
        ndd = ndd << 1;
        nof = nof | nq[QW-1];
        if (t >= {1'b0, pdv}) begin
          nrm = VW'(t - {1'b0, pdv});
          nq  = {nq[QW-2:0], 1'b1};
        end else begin
          nrm = t[VW-1:0];
          nq  = {nq[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en) begin
        v[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm[s] <= nrm;
        dd[s] <= ndd;
        dv[s] <= pdv;
        q[s]  <= nq;
        of[s] <= nof;
        sb[s] <= psb;
      end
    end
  end

  assign out_valid = v[NS-1];
  assign quot      = q[NS-1];
  assign ovf       = of[NS-1];
  assign out_side  = sb[NS-1];

endmodule

FILE: rtl/lab_cordic.sv
// Pipelined CORDIC rotator giving |sin| of a phase in turns, one stage per iteration.
module lab_cordic #(
  parameter int STAGES = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [lab_pkg::PHASE_W-1:0] phase,
  output logic                     out_valid,
  output logic [lab_pkg::SIN_W-1:0]   mag
);
  import lab_pkg::*;

  logic                     v [STAGES];
  logic signed [CORD_W-1:0] x [STAGES];
  logic signed [CORD_W-1:0] y [STAGES];
  logic signed [CORD_W-1:0] z [STAGES];

  // fold into [-1/4, 1/4) turn; sign of sine is dropped
  logic [PHASE_W-1:0] fold;
  logic [PHASE_W-1:0] quarter_chk;
  assign quarter_chk = phase + 32'h4000_0000;
  assign fold = quarter_chk[PHASE_W-1] ? phase - 32'h8000_0000 : phase;

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    logic                     pv;
    logic signed [CORD_W-1:0] px, py, pz, nx, ny, nz, at;

    if (i == 0) begin : g_first
      assign pv = in_valid;
      assign px = signed'(CORDIC_K);
      assign py = '0;
      assign pz = signed'({{(CORD_W-PHASE_W){fold[PHASE_W-1]}}, fold});
    end else begin : g_next
      assign pv = v[i-1];
      assign px = x[i-1];
      assign py = y[i-1];
      assign pz = z[i-1];
    end

    assign at = signed'({{(CORD_W-32){1'b0}}, ATAN_TURNS[i]});

    always_comb begin
      if (!pz[CORD_W-1]) begin
        nx = px - (py >>> i);
        ny = py + (px >>> i);
        nz = pz - at;
      end else begin
        nx = px + (py >>> i);
        ny = py - (px >>> i);
        nz = pz + at;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x[i] <= nx;
        y[i] <= ny;
        z[i] <= nz;
      end
    end
  end

  logic signed [CORD_W-1:0] y_abs;
  assign y_abs     = y[STAGES-1][CORD_W-1] ? -y[STAGES-1] : y[STAGES-1];
  assign out_valid = v[STAGES-1];
  assign mag       = y_abs[SIN_W-1:0];

endmodule

FILE: rtl/line_array_beam_gain_top.sv
// Top level: power array factor |sin(Nx)/(N sin x)|^2 of a uniform line array.
//
// One item (arrival and steering direction cosines plus a frequency) can be
// accepted every clock; each gives exactly one gain result. The datapath is a
// single pipeline that advances as a whole: it stalls only while a finished
// result sits in the output register and the sink holds ready low, and in_ch
// ready is high whenever that register is empty or being drained. Items pass
// through stages A and B, the phase divider (spacing*freq*|d| / speed, 4 bits a
// stage), stage C, the two parallel CORDIC rotators (one stage per iteration),
// stage D, the ratio divider (2 bits a stage) and the output register.
// Configuration is an APB slave at byte addresses 0, 4, 8, 12 (line_axis,
// element_count, element_spacing, wave_speed); write it only while no
// transfer is in flight. Zero count or speed are used as 1, counts above
// MAX_ELEMENTS saturate. Main and grating lobes (|sin x| below 2^-15) give
// 65535, as does any ratio of 1.0 or more. No reset sweep is needed.
module line_array_beam_gain_top #(
  parameter int MAX_ELEMENTS  = lab_pkg::MAX_ELEMENTS_DEF,
  parameter int CORDIC_STAGES = lab_pkg::CORDIC_STAGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lab_pkg::APB_AW-1:0] paddr,
  input  logic [lab_pkg::APB_DW-1:0] pwdata,
  output logic [lab_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  lab_in_if.sink                     in_ch,
  lab_out_if.source                  out_ch
);
  import lab_pkg::*;

  localparam int NW    = $clog2(MAX_ELEMENTS + 1);  // element count width
  localparam int DEN_W = NW + SIN_W;
  localparam int RQ_W  = GAIN_W + 1;                 // ratio quotient, bit 16 = overflow

  // ---------------------------------------------------------------- config
  logic               line_axis;
  logic [COUNT_W-1:0] element_count;
  logic [SPACE_W-1:0] element_spacing;
  logic [SPEED_W-1:0] wave_speed;
  reg_idx_t           wr_idx;

  assign pready = 1'b1;
  assign wr_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_axis       <= 1'b0;
      element_count   <= COUNT_W'(8);
      element_spacing <= SPACE_W'(49152);
      wave_speed      <= SPEED_W'(1500);
    end else if (psel && penable && pwrite) begin
      case (wr_idx)
        REG_LINE_AXIS: line_axis       <= pwdata[0];
        REG_ELEM_CNT:  element_count   <= pwdata[COUNT_W-1:0];
        REG_SPACING:   element_spacing <= pwdata[SPACE_W-1:0];
        REG_SPEED:     wave_speed      <= pwdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      REG_LINE_AXIS: prdata = APB_DW'(line_axis);
      REG_ELEM_CNT:  prdata = APB_DW'(element_count);
      REG_SPACING:   prdata = APB_DW'(element_spacing);
      REG_SPEED:     prdata = APB_DW'(wave_speed);
      default:       prdata = '0;
    endcase
  end

  // effective N and speed; the user must keep config static while items are in flight, the block does not enforce it
  logic [NW-1:0]      n_eff;
  logic [SPEED_W-1:0] speed_eff;

  always_comb begin
    if (element_count == '0) begin
      n_eff = NW'(1);
    end else if (32'(element_count) > 32'(MAX_ELEMENTS)) begin
      n_eff = NW'(MAX_ELEMENTS);
    end else begin
      n_eff = NW'(element_count);
    end
  end

  assign speed_eff = (wave_speed == '0) ? SPEED_W'(1) : wave_speed;

  // ------------------------------------------------------------ flow control
  // whole-pipeline advance: move unless a result is held at the output
  logic en;
  logic e_v;
  logic [GAIN_W-1:0] e_gain;

  assign en          = !e_v || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------------------------------------- stage A: |d| and spacing*f
  logic signed [DIR_W:0] diff;
  logic                  a_v;
  logic [MAG_W-1:0]      a_mag;
  logic [SPACE_W+FREQ_W-1:0] a_sf;

  always_comb begin
    if (line_axis) begin
      diff = (DIR_W+1)'(in_ch.arrival_up) - (DIR_W+1)'(in_ch.steer_up);
    end else begin
      diff = (DIR_W+1)'(in_ch.arrival_front) - (DIR_W+1)'(in_ch.steer_front);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag <= diff[DIR_W] ? MAG_W'(-diff) : MAG_W'(diff);
      a_sf  <= element_spacing * in_ch.frequency_hz;
    end
  end

  // ------------------------------------------ stage B: phase numerator
  logic             b_v;
  logic [NUM_W-1:0] b_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_num <= a_sf * a_mag;
    end
  end

  // phase p = num / speed, kept mod 2^32
  logic               p_v;
  logic [PHASE_W-1:0] p_q;
  logic               p_side;

  lab_div #(
    .DW (NUM_W),
    .VW (SPEED_W),
    .QW (PHASE_W),
    .BPS(4),
    .SW (1)
  ) u_phase_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (b_v),
    .dividend (b_num),
    .divisor  (speed_eff),
    .side     (1'b0),
    .out_valid(p_v),
    .quot     (p_q),
    .ovf      (),
    .out_side (p_side)
  );

  // ------------------------------------------ stage C: phase of N x
  logic               c_v;
  logic [PHASE_W-1:0] c_p;
  logic [PHASE_W-1:0] c_pn;
  logic [PHASE_W+NW-1:0] pn_full;

  assign pn_full = p_q * n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_p  <= p_q | PHASE_W'(p_side);  // side is tied low
      c_pn <= pn_full[PHASE_W-1:0];
    end
  end

  // two rotators in lockstep: sin x and sin N x
  logic             s_v;
  logic [SIN_W-1:0] s1;
  logic [SIN_W-1:0] sn;

  lab_cordic #(.STAGES(CORDIC_STAGES)) u_sin_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c_v),
    .phase    (c_p),
    .out_valid(s_v),
    .mag      (s1)
  );

  lab_cordic #(.STAGES(CORDIC_STAGES)) u_sin_nx (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c_v),
    .phase    (c_pn),
    .out_valid(),
    .mag      (sn)
  );

  // ------------------------------------------ stage D: lobe test, N*|sin x|
  logic             d_v;
  logic             d_lobe;
  logic [SIN_W-1:0] d_sn;
  logic [DEN_W-1:0] d_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= s_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_lobe <= (s1 < LOBE_FLOOR);
      d_sn   <= sn;
      d_den  <= n_eff * s1;
    end
  end

  // ratio r = (sn << 16) / den
  logic            r_v;
  logic [RQ_W-1:0] r_q;
  logic            r_ovf;
  logic            r_lobe;

  lab_div #(
    .DW (SIN_W + GAIN_W),
    .VW (DEN_W),
    .QW (RQ_W),
    .BPS(2),
    .SW (1)
  ) u_ratio_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d_v),
    .dividend ({d_sn, {GAIN_W{1'b0}}}),
    .divisor  (d_den),
    .side     (d_lobe),
    .out_valid(r_v),
    .quot     (r_q),
    .ovf      (r_ovf),
    .out_side (r_lobe)
  );

  // ------------------------------------------ stage E: square, saturate
  logic [2*GAIN_W-1:0] r_sq;
  assign r_sq = r_q[GAIN_W-1:0] * r_q[GAIN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en) begin
      e_v <= r_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (r_lobe || r_ovf || r_q[GAIN_W]) begin
        e_gain <= GAIN_MAX;
      end else begin
        e_gain <= r_sq[2*GAIN_W-1:GAIN_W];
      end
    end
  end

  assign out_ch.valid = e_v;
  assign out_ch.gain  = e_gain;

  // ------------------------------------------------------------ assertions
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("result valid after reset");

  a_stall_holds_mid: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(d_v) && $stable(d_den) && $stable(c_v))
    else $error("pipeline moved while stalled");

  a_lobe_saturates: assert property (@(posedge clk) disable iff (rst)
    (en && r_v && r_lobe) |=> (out_ch.valid && out_ch.gain == GAIN_MAX))
    else $error("lobe item did not give unity gain");

endmodule
